// ===== rtl/ntf_pkg.sv =====
// ntf_pkg: shared constants, control types and helpers for the number to text formatter.
// Depends on nothing; used by every module under rtl except ntf_checker.
package ntf_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_WIDTH_DEF  = 63;
	localparam int MAX_RESULTS    = 63;
	localparam int SPACE_W        = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] RADIX_OCT   = 2'd0;
	localparam logic [1:0] RADIX_DEC   = 2'd1;
	localparam logic [1:0] RADIX_HEX   = 2'd2;
	localparam logic [1:0] RADIX_RESET = RADIX_HEX;

	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_DABBLE = 2'd2;
	localparam logic [1:0] OP_SHIFT  = 2'd3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_ALPHA = 8'h57;

	typedef struct packed {
		logic [1:0] op;
		logic       oct;
		logic       dec;
	} digit_ctl_t;

	function automatic int num_digits(input int vb);
		int noct;
		int nhex;
		int ndec;
		int n;
		noct = (vb + 2) / 3 + 1;
		nhex = (vb + 3) / 4;
		ndec = (vb * 30103) / 100000 + 1;
		n = noct;
		if (nhex > n) n = nhex;
		if (ndec > n) n = ndec;
		return n;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] ch;
		if (d < 4'd10) ch = CH_ZERO + {4'd0, d};
		else ch = CH_ALPHA + {4'd0, d};
		return ch;
	endfunction

endpackage

// ===== rtl/ntf_digit_unit.sv =====
// ntf_digit_unit: digit register with its shared load, double-dabble and digit-shift unit.
// Depends on ntf_pkg for the operation codes and the control struct.
module ntf_digit_unit #(
	parameter int VALUE_BITS = ntf_pkg::VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  ntf_pkg::digit_ctl_t     ctl,
	input  logic [VALUE_BITS-1:0]   operand,
	output logic [3:0]              top_digit
);

	localparam int NDIG = ntf_pkg::num_digits(VALUE_BITS);
	localparam int DW   = 4 * NDIG;
	localparam int OW   = 3 * NDIG;

	logic [DW-1:0]         dig_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [OW-1:0]         ext3;
	logic [DW-1:0]         ext4;
	logic [DW-1:0]         oct_load;
	logic [DW-1:0]         adj;

	assign ext3 = {{(OW - VALUE_BITS){1'b0}}, operand};
	assign ext4 = {{(DW - VALUE_BITS){1'b0}}, operand};
	assign top_digit = dig_q[DW-1 -: 4];

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			oct_load[4*i +: 4] = {1'b0, ext3[3*i +: 3]};
			adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
				: dig_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			ntf_pkg::OP_LOAD: begin
				bin_q <= operand;
				if (ctl.oct) dig_q <= oct_load;
				else if (ctl.dec) dig_q <= '0;
				else dig_q <= ext4;
			end
			ntf_pkg::OP_DABBLE: begin
				dig_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
				bin_q <= bin_q << 1;
			end
			ntf_pkg::OP_SHIFT: begin
				dig_q <= {dig_q[DW-5:0], 4'd0};
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/ntf_seq.sv =====
// ntf_seq: sequencer that drives the digit unit, sizes the padding and emits characters.
// Depends on ntf_pkg; controls one ntf_digit_unit.
module ntf_seq #(
	parameter int VALUE_BITS = ntf_pkg::VALUE_BITS_DEF,
	parameter int MAX_WIDTH  = ntf_pkg::MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            radix,
	input  logic [VALUE_BITS-1:0] value_bits,
	input  logic [5:0]            field_width,
	input  logic [3:0]            top_digit,
	output logic                  busy,
	output ntf_pkg::digit_ctl_t   ctl,
	output logic [VALUE_BITS-1:0] operand,
	output logic                  char_valid,
	output logic [7:0]            char_code,
	output logic                  last_char
);

	localparam int NDIG   = ntf_pkg::num_digits(VALUE_BITS);
	localparam int CNT_W  = $clog2(NDIG + 1);
	localparam int VB_W   = $clog2(VALUE_BITS + 1);
	localparam int STEP_W = (VB_W > ntf_pkg::SPACE_W) ? VB_W : ntf_pkg::SPACE_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DABBLE = 4'd1;
	localparam logic [3:0] ST_NORM   = 4'd2;
	localparam logic [3:0] ST_CALC   = 4'd3;
	localparam logic [3:0] ST_SPACE  = 4'd4;
	localparam logic [3:0] ST_SIGN   = 4'd5;
	localparam logic [3:0] ST_LEAD   = 4'd6;
	localparam logic [3:0] ST_QMARK  = 4'd7;
	localparam logic [3:0] ST_DIGIT  = 4'd8;

	localparam logic [VALUE_BITS-1:0] SIGN_VAL = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] ONE_VAL  = {{(VALUE_BITS-1){1'b0}}, 1'b1};

	logic [3:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              minus_q, qmark_q, lead_q;
	logic signed [7:0] w_q;
	logic              char_valid_q, last_q;
	logic [7:0]        char_q;

	logic              is_oct, is_dec, neg, qm;
	logic [5:0]        wclamp;
	logic [7:0]        nd, lim;
	logic signed [7:0] sp_raw;
	logic [ntf_pkg::SPACE_W-1:0] spaces_calc;
	logic [3:0]        after_space;
	logic              emit_v, emit_l;
	logic [7:0]        emit_c;

	assign is_oct  = (radix == ntf_pkg::RADIX_OCT);
	assign is_dec  = (radix == ntf_pkg::RADIX_DEC);
	assign neg     = is_dec && value_bits[VALUE_BITS-1];
	assign qm      = neg && (value_bits == SIGN_VAL);
	assign operand = neg ? (~value_bits) + ONE_VAL : value_bits;
	assign wclamp  = (field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width;

	assign nd     = 8'(cnt_q) + {7'd0, lead_q};
	assign sp_raw = w_q - signed'(nd) + 8'sd1;
	assign lim    = 8'(ntf_pkg::MAX_RESULTS) - nd - {7'd0, minus_q};
	assign spaces_calc = sp_raw[7] ? '0
		: ((unsigned'(sp_raw) > lim) ? ntf_pkg::SPACE_W'(lim)
		: ntf_pkg::SPACE_W'(unsigned'(sp_raw)));

	assign after_space = minus_q ? ST_SIGN : (lead_q ? ST_LEAD
		: (qmark_q ? ST_QMARK : ST_DIGIT));

	assign busy       = (state_q != ST_IDLE);
	assign char_valid = char_valid_q;
	assign char_code  = char_q;
	assign last_char  = last_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		step_d  = step_q;
		ctl     = '{op: ntf_pkg::OP_HOLD, oct: is_oct, dec: is_dec};
		emit_v  = 1'b0;
		emit_l  = 1'b0;
		emit_c  = ntf_pkg::CH_SPACE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.op = ntf_pkg::OP_LOAD;
					cnt_d  = CNT_W'(NDIG);
					step_d = STEP_W'(VALUE_BITS);
					if (qm) begin
						state_d = ST_CALC;
						cnt_d   = CNT_W'(1);
					end else if (is_dec) begin
						state_d = ST_DABBLE;
					end else begin
						state_d = ST_NORM;
					end
				end
			end
			ST_DABBLE: begin
				ctl.op = ntf_pkg::OP_DABBLE;
				step_d = step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (cnt_q > CNT_W'(1) && top_digit == 4'd0) begin
					ctl.op = ntf_pkg::OP_SHIFT;
					cnt_d  = cnt_q - CNT_W'(1);
				end else begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				step_d  = STEP_W'(spaces_calc);
				state_d = (spaces_calc != '0) ? ST_SPACE : after_space;
			end
			ST_SPACE: begin
				emit_v = 1'b1;
				step_d = step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) state_d = after_space;
			end
			ST_SIGN: begin
				emit_v  = 1'b1;
				emit_c  = ntf_pkg::CH_MINUS;
				state_d = ST_DIGIT;
			end
			ST_LEAD: begin
				emit_v  = 1'b1;
				emit_c  = ntf_pkg::CH_ZERO;
				state_d = ST_DIGIT;
			end
			ST_QMARK: begin
				emit_v  = 1'b1;
				emit_l  = 1'b1;
				emit_c  = ntf_pkg::CH_QMARK;
				state_d = ST_IDLE;
			end
			ST_DIGIT: begin
				emit_v = 1'b1;
				emit_c = ntf_pkg::digit_char(top_digit);
				ctl.op = ntf_pkg::OP_SHIFT;
				cnt_d  = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					emit_l  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			step_q       <= '0;
			minus_q      <= 1'b0;
			qmark_q      <= 1'b0;
			lead_q       <= 1'b0;
			w_q          <= '0;
			char_valid_q <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			step_q       <= step_d;
			char_valid_q <= emit_v;
			last_q       <= emit_l;
			if (state_q == ST_IDLE && start) begin
				minus_q <= neg && !qm;
				qmark_q <= qm;
				lead_q  <= is_oct && (value_bits != '0);
				w_q     <= signed'({2'b00, wclamp}) - signed'({7'd0, neg});
			end
		end
	end

	always_ff @(posedge clk) begin
		char_q <= emit_c;
	end

endmodule

// ===== rtl/number_to_text_formatter.sv =====
// number_to_text_formatter: radix register plus sequencer and digit unit.
// Busy covers the dabble steps, VALUE_BITS of them in decimal (none otherwise), the leading
// zero digits dropped one per cycle and the characters emitted one per cycle; the most negative
// decimal skips the dabble steps and the dropping. Characters leave an output register, and
// the next start is taken in the cycle the last character is shown.
// The receiver cannot stall. Reset clears sequencer and strobes, sets the radix to hexadecimal.
module number_to_text_formatter #(
	parameter int VALUE_BITS = ntf_pkg::VALUE_BITS_DEF,
	parameter int MAX_WIDTH  = ntf_pkg::MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value_bits,
	input  logic [5:0]            field_width,
	input  logic                  radix_we,
	input  logic [1:0]            radix_wdata,
	output logic                  char_valid,
	output logic [7:0]            char_code,
	output logic                  last_char
);

	logic [1:0]            radix_q;
	ntf_pkg::digit_ctl_t   ctl;
	logic [VALUE_BITS-1:0] operand;
	logic [3:0]            top_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= ntf_pkg::RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	ntf_seq #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.radix       (radix_q),
		.value_bits  (value_bits),
		.field_width (field_width),
		.top_digit   (top_digit),
		.busy        (busy),
		.ctl         (ctl),
		.operand     (operand),
		.char_valid  (char_valid),
		.char_code   (char_code),
		.last_char   (last_char)
	);

	ntf_digit_unit #(
		.VALUE_BITS (VALUE_BITS)
	) u_digit (
		.clk       (clk),
		.ctl       (ctl),
		.operand   (operand),
		.top_digit (top_digit)
	);

endmodule

// ===== rtl/ntf_checker.sv =====
// ntf_checker: port-level checks on the formatter's command and character beats.
// Depends only on the top level's handshake ports; bound to number_to_text_formatter below.
module ntf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic char_valid,
	input logic last_char
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted start");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && last_char) |-> !busy)
		else $error("still busy on final character beat");

	a_idle_no_chars: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && char_valid) |-> last_char)
		else $error("non-final character beat while idle");

	a_chars_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !last_char) |=> char_valid)
		else $error("gap in character beats");

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> char_valid)
		else $error("last flag without character strobe");

endmodule

bind number_to_text_formatter ntf_checker u_ntf_checker (.*);
